FILE: rtl/pfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, codes and helpers of the filtered-derivative PID controller.
// ----------------------------------------------------------------------------
package pfd_pkg;

	typedef logic signed [63:0] wide_t;

	// configuration register indexes
	localparam logic [2:0] REG_KP       = 3'd0;
	localparam logic [2:0] REG_TI       = 3'd1;
	localparam logic [2:0] REG_TD       = 3'd2;
	localparam logic [2:0] REG_FILTER_N = 3'd3;
	localparam logic [2:0] REG_OUT_MAX  = 3'd4;
	localparam logic [2:0] REG_INT_LIM  = 3'd5;

	// transaction kinds
	localparam logic [2:0] KIND_COMPUTE = 3'd0;
	localparam logic [2:0] KIND_GIVEN_D = 3'd1;
	localparam logic [2:0] KIND_RESET   = 3'd2;
	localparam logic [2:0] KIND_PRESET  = 3'd3;
	localparam logic [2:0] KIND_INT_EN  = 3'd4;

	// multiplier result shift codes
	localparam logic [1:0] SH16 = 2'd0;
	localparam logic [1:0] SH17 = 2'd1;
	localparam logic [1:0] SH31 = 2'd2;
	localparam logic [1:0] SH71 = 2'd3;

	// product magnitude saturation point
	localparam logic [63:0] MUL_LIM = 64'h2000_0000_0000_0000;
	localparam logic [63:0] US_PER_S = 64'd1000000;

	// 2^31 / 1e6 is 2^25 / 15625; ceil(2^71 / 15625) gives an exact floor
	// quotient by 15625 for any dividend below 2^57 after a shift by 71
	localparam logic [63:0] DT_RECIP = 64'(((128'd1 << 71) + 128'd15624) / 128'd15625);

	// reset values of the registers
	localparam logic [31:0] KP_RST       = 32'h0001_0000;
	localparam logic [31:0] FILTER_N_RST = 32'h0005_0000;
	localparam logic [30:0] LIM_RST      = 31'h7FFF_FFFF;

	function automatic wide_t sx32(input logic [31:0] v);
		return signed'({{32{v[31]}}, v});
	endfunction

	// symmetric clamp to +-lim, result fits 32 bits
	function automatic logic [31:0] clamp_lim(input wide_t v, input logic [30:0] lim);
		wide_t hi;
		wide_t lo;
		wide_t r;
		hi = signed'({33'b0, lim});
		lo = -hi;
		if (v > hi) r = hi;
		else if (v < lo) r = lo;
		else r = v;
		return r[31:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/pid_filtered_derivative.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pid_filtered_derivative
// Timestamped Q16.16 PID controller with filtered derivative and anti-windup.
// ----------------------------------------------------------------------------
// One transaction is in work at a time; in_ready is high only while idle. All
// products and quotients run through one bit-serial 64/64 divider and one 64x64
// multiplier built from four 32x32 partial products. The time step comes from
// the timestamp difference through a reciprocal product, so it costs one product.
// A kind 0 compute with integral and derivative active takes two divisions and
// nine products. The divider sets the rate. A finished result waits in the
// output register while the next transaction is taken in; while that register
// is still full, the next result is held until the receiver takes it.
// ----------------------------------------------------------------------------
module pid_filtered_derivative import pfd_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [2:0]         kind,
	input  wire logic signed [31:0] error,
	input  wire logic signed [31:0] error_derivative,
	input  wire logic               error_invalid,
	input  wire logic [31:0]        timestamp_us,
	input  wire logic signed [31:0] preset_output,
	input  wire logic               integral_enable,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      command,
	output logic signed [31:0]      integral_value,
	output logic signed [31:0]      derivative_value
);

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_DECODE  = 5'd1;
	localparam logic [4:0] ST_MWAIT   = 5'd2;
	localparam logic [4:0] ST_DWAIT   = 5'd3;
	localparam logic [4:0] ST_DT_DONE = 5'd4;
	localparam logic [4:0] ST_GI_DONE = 5'd5;
	localparam logic [4:0] ST_INC1    = 5'd6;
	localparam logic [4:0] ST_INC2    = 5'd7;
	localparam logic [4:0] ST_DER     = 5'd8;
	localparam logic [4:0] ST_DEN     = 5'd9;
	localparam logic [4:0] ST_A_DONE  = 5'd10;
	localparam logic [4:0] ST_B1      = 5'd11;
	localparam logic [4:0] ST_B2      = 5'd12;
	localparam logic [4:0] ST_P       = 5'd13;
	localparam logic [4:0] ST_Q       = 5'd14;
	localparam logic [4:0] ST_K1_KTD  = 5'd15;
	localparam logic [4:0] ST_K1_D    = 5'd16;
	localparam logic [4:0] ST_FIN     = 5'd17;
	localparam logic [4:0] ST_CMD     = 5'd18;
	localparam logic [4:0] ST_OUT     = 5'd19;
	localparam logic [4:0] ST_K3_KTD  = 5'd20;
	localparam logic [4:0] ST_K3_D    = 5'd21;
	localparam logic [4:0] ST_K3_I    = 5'd22;

	// configuration
	logic [31:0] kp_q, ti_q, td_q, filter_n_q;
	logic [30:0] out_max_q, int_lim_q;

	// controller state
	logic [31:0] prev_err_q, int_sum_q, der_q, prev_time_q;
	logic        int_en_q;

	// sequencer
	logic [4:0]  state_q, ret_q;
	logic        out_valid_q;

	// latched transaction and temporaries
	logic [2:0]  kind_q;
	logic [31:0] e_q, ed_q, t_q, preset_q;
	logic        inv_q, en_q;
	logic [63:0] dt_q, a_q;
	wide_t       b_q, p_q;
	logic [31:0] command_q, int_out_q, der_out_q;

	// shared units
	logic        mul_start, div_start;
	wide_t       mul_a, mul_b;
	logic [1:0]  mul_sh;
	logic [63:0] div_n, div_d;
	logic        mul_busy_q, div_busy_q;
	logic [2:0]  mcnt_q;
	logic [5:0]  dcnt_q;
	logic [63:0] mag_a_q, mag_b_q;
	logic        neg_q;
	logic [1:0]  sh_q;
	logic [127:0] acc_q;
	wide_t       mres_q;
	logic [63:0] dvd_q, dsr_q, rem_q;

	logic        in_acc, run_ok, int_on, out_load;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign run_ok   = (kind_q == KIND_COMPUTE || kind_q == KIND_GIVEN_D) && !inv_q &&
		!(prev_time_q > t_q);
	assign int_on   = (ti_q != 32'd0) && int_en_q;
	assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	// operation issue per sequencer step
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		mul_sh    = SH16;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		unique case (state_q)
			ST_DECODE: begin
				if (run_ok) begin
					// time step: dt_us * 2^25 / 15625 by reciprocal product
					mul_start = 1'b1;
					mul_a     = signed'({7'b0, t_q - prev_time_q, 25'b0});
					mul_b     = signed'(DT_RECIP);
					mul_sh    = SH71;
				end else if (kind_q == KIND_PRESET) begin
					mul_start = 1'b1;
					mul_a     = signed'({32'b0, kp_q});
					mul_b     = signed'({32'b0, td_q});
				end
			end
			ST_DT_DONE: begin
				div_start = int_on;
				div_n     = {16'b0, kp_q, 16'b0};
				div_d     = {32'b0, ti_q};
			end
			ST_GI_DONE: begin
				mul_start = 1'b1;
				mul_a     = signed'(dvd_q);
				mul_b     = signed'(dt_q);
				mul_sh    = SH31;
			end
			ST_INC1: begin
				mul_start = 1'b1;
				mul_a     = mres_q;
				mul_b     = sx32(e_q) + sx32(prev_err_q);
				mul_sh    = SH17;
			end
			ST_DER: begin
				if (kind_q == KIND_COMPUTE) begin
					mul_start = (kp_q != 32'd0) && (td_q != 32'd0);
					mul_a     = signed'({32'b0, filter_n_q});
					mul_b     = signed'(dt_q);
					mul_sh    = SH31;
				end else begin
					mul_start = (kp_q != 32'd0);
					mul_a     = signed'({32'b0, kp_q});
					mul_b     = signed'({32'b0, td_q});
				end
			end
			ST_DEN: begin
				div_start = 1'b1;
				div_n     = {1'b0, td_q, 31'b0};
				div_d     = {32'b0, td_q} + 64'(mres_q);
			end
			ST_A_DONE: begin
				mul_start = 1'b1;
				mul_a     = signed'({32'b0, kp_q});
				mul_b     = signed'({32'b0, filter_n_q});
			end
			ST_B1: begin
				mul_start = 1'b1;
				mul_a     = mres_q;
				mul_b     = signed'(a_q);
				mul_sh    = SH31;
			end
			ST_B2: begin
				mul_start = 1'b1;
				mul_a     = signed'(a_q);
				mul_b     = sx32(der_q);
				mul_sh    = SH31;
			end
			ST_P: begin
				mul_start = 1'b1;
				mul_a     = b_q;
				mul_b     = sx32(e_q) - sx32(prev_err_q);
			end
			ST_K1_KTD, ST_K3_KTD: begin
				mul_start = 1'b1;
				mul_a     = mres_q;
				mul_b     = sx32(ed_q);
			end
			ST_K3_D: begin
				mul_start = 1'b1;
				mul_a     = signed'({32'b0, kp_q});
				mul_b     = sx32(e_q);
			end
			ST_CMD: begin
				mul_start = 1'b1;
				mul_a     = signed'({32'b0, kp_q});
				mul_b     = sx32(prev_err_q);
			end
			default: ;
		endcase
	end

	// multiplier partial product and final shift
	logic [31:0]  pa, pb;
	logic [63:0]  pp;
	logic [127:0] pp_sh, acc_sh;
	logic [63:0]  mul_r;

	always_comb begin
		pa = mcnt_q[0] ? mag_a_q[63:32] : mag_a_q[31:0];
		pb = mcnt_q[1] ? mag_b_q[63:32] : mag_b_q[31:0];
		pp = 64'(pa) * 64'(pb);
		case (mcnt_q[1:0])
			2'd0:    pp_sh = {64'b0, pp};
			2'd3:    pp_sh = {pp, 64'b0};
			default: pp_sh = {32'b0, pp, 32'b0};
		endcase
		case (sh_q)
			SH16:    acc_sh = acc_q >> 16;
			SH17:    acc_sh = acc_q >> 17;
			SH31:    acc_sh = acc_q >> 31;
			default: acc_sh = acc_q >> 71;
		endcase
		mul_r = (acc_sh > {64'b0, MUL_LIM}) ? MUL_LIM : acc_sh[63:0];
	end

	// multiplier control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_busy_q <= 1'b0;
			mcnt_q     <= '0;
		end else if (mul_start) begin
			mul_busy_q <= 1'b1;
			mcnt_q     <= '0;
		end else if (mul_busy_q) begin
			if (mcnt_q == 3'd4) mul_busy_q <= 1'b0;
			else mcnt_q <= mcnt_q + 3'd1;
		end
	end

	// multiplier datapath
	always_ff @(posedge clk) begin
		if (mul_start) begin
			mag_a_q <= mul_a[63] ? 64'(-mul_a) : 64'(mul_a);
			mag_b_q <= mul_b[63] ? 64'(-mul_b) : 64'(mul_b);
			neg_q   <= mul_a[63] ^ mul_b[63];
			sh_q    <= mul_sh;
			acc_q   <= '0;
		end else if (mul_busy_q) begin
			if (mcnt_q == 3'd4) mres_q <= neg_q ? -signed'(mul_r) : signed'(mul_r);
			else acc_q <= acc_q + pp_sh;
		end
	end

	// restoring divider, one quotient bit per cycle
	logic [64:0] rem_sh;
	logic        rem_ge;

	assign rem_sh = {rem_q, dvd_q[63]};
	assign rem_ge = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			dcnt_q     <= '0;
		end else if (div_start) begin
			div_busy_q <= 1'b1;
			dcnt_q     <= '0;
		end else if (div_busy_q) begin
			if (dcnt_q == 6'd63) div_busy_q <= 1'b0;
			dcnt_q <= dcnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			dvd_q <= div_n;
			dsr_q <= div_d;
			rem_q <= '0;
		end else if (div_busy_q) begin
			rem_q <= rem_ge ? 64'(rem_sh - {1'b0, dsr_q}) : rem_sh[63:0];
			dvd_q <= {dvd_q[62:0], rem_ge};
		end
	end

	// sequencer, configuration and controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q        <= KP_RST;
			ti_q        <= '0;
			td_q        <= '0;
			filter_n_q  <= FILTER_N_RST;
			out_max_q   <= LIM_RST;
			int_lim_q   <= LIM_RST;
			prev_err_q  <= '0;
			int_sum_q   <= '0;
			der_q       <= '0;
			prev_time_q <= '0;
			int_en_q    <= 1'b1;
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_KP:       kp_q       <= cfg_data;
					REG_TI:       ti_q       <= cfg_data;
					REG_TD:       td_q       <= cfg_data;
					REG_FILTER_N: filter_n_q <= cfg_data;
					REG_OUT_MAX:  out_max_q  <= cfg_data[30:0];
					REG_INT_LIM:  int_lim_q  <= cfg_data[30:0];
					default: ;
				endcase
			end
			// output register occupancy
			if (out_load) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_DECODE;
				ST_DECODE: begin
					if (run_ok) begin
						state_q <= ST_MWAIT;
						ret_q   <= ST_DT_DONE;
					end else begin
						case (kind_q)
							KIND_RESET: begin
								prev_err_q  <= e_q;
								int_sum_q   <= '0;
								der_q       <= '0;
								prev_time_q <= t_q;
								state_q     <= ST_CMD;
							end
							KIND_PRESET: begin
								state_q <= ST_MWAIT;
								ret_q   <= ST_K3_KTD;
							end
							KIND_INT_EN: begin
								if (en_q != int_en_q) int_sum_q <= '0;
								int_en_q <= en_q;
								state_q  <= ST_CMD;
							end
							default: state_q <= ST_CMD;
						endcase
					end
				end
				ST_MWAIT: if (!mul_busy_q) state_q <= ret_q;
				ST_DWAIT: if (!div_busy_q) state_q <= ret_q;
				ST_DT_DONE: begin
					prev_time_q <= t_q;
					if (int_on) begin
						state_q <= ST_DWAIT;
						ret_q   <= ST_GI_DONE;
					end else begin
						int_sum_q <= '0;
						state_q   <= ST_DER;
					end
				end
				ST_GI_DONE: begin
					state_q <= ST_MWAIT;
					ret_q   <= ST_INC1;
				end
				ST_INC1: begin
					state_q <= ST_MWAIT;
					ret_q   <= ST_INC2;
				end
				ST_INC2: begin
					int_sum_q <= clamp_lim(sx32(int_sum_q) + mres_q, int_lim_q);
					state_q   <= ST_DER;
				end
				ST_DER: begin
					if (mul_start) begin
						state_q <= ST_MWAIT;
						ret_q   <= (kind_q == KIND_COMPUTE) ? ST_DEN : ST_K1_KTD;
					end else begin
						if (kind_q == KIND_COMPUTE) der_q <= '0;
						state_q <= ST_FIN;
					end
				end
				ST_DEN: begin
					state_q <= ST_DWAIT;
					ret_q   <= ST_A_DONE;
				end
				ST_A_DONE: begin
					state_q <= ST_MWAIT;
					ret_q   <= ST_B1;
				end
				ST_B1: begin
					state_q <= ST_MWAIT;
					ret_q   <= ST_B2;
				end
				ST_B2: begin
					state_q <= ST_MWAIT;
					ret_q   <= ST_P;
				end
				ST_P: begin
					state_q <= ST_MWAIT;
					ret_q   <= ST_Q;
				end
				ST_Q: begin
					der_q   <= clamp_lim(p_q + mres_q, out_max_q);
					state_q <= ST_FIN;
				end
				ST_K1_KTD: begin
					state_q <= ST_MWAIT;
					ret_q   <= ST_K1_D;
				end
				ST_K1_D: begin
					der_q   <= clamp_lim(mres_q, out_max_q);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					prev_err_q <= e_q;
					state_q    <= ST_CMD;
				end
				ST_CMD: begin
					state_q <= ST_MWAIT;
					ret_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				ST_K3_KTD: begin
					state_q <= ST_MWAIT;
					ret_q   <= ST_K3_D;
				end
				ST_K3_D: begin
					der_q   <= clamp_lim(mres_q, out_max_q);
					state_q <= ST_MWAIT;
					ret_q   <= ST_K3_I;
				end
				ST_K3_I: begin
					int_sum_q   <= clamp_lim(sx32(preset_q) - mres_q - sx32(der_q), int_lim_q);
					prev_err_q  <= e_q;
					prev_time_q <= t_q;
					state_q     <= ST_CMD;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// transaction latch, temporaries and result register
	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q   <= kind;
			e_q      <= error;
			ed_q     <= error_derivative;
			inv_q    <= error_invalid;
			t_q      <= timestamp_us;
			preset_q <= preset_output;
			en_q     <= integral_enable;
		end
		if (state_q == ST_DT_DONE) dt_q <= mres_q;
		if (state_q == ST_A_DONE) a_q <= dvd_q;
		if (state_q == ST_B2) b_q <= mres_q;
		if (state_q == ST_P) p_q <= mres_q;
		if (out_load) begin
			command_q <= clamp_lim(mres_q + sx32(int_sum_q) + sx32(der_q), out_max_q);
			int_out_q <= int_sum_q;
			der_out_q <= der_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign command          = signed'(command_q);
	assign integral_value   = signed'(int_out_q);
	assign derivative_value = signed'(der_out_q);

	// the two shared units never run together
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_busy_q && div_busy_q))
		else $error("multiplier and divider busy together");

	// no unit is running while a new transaction can be taken
	a_idle_units: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !mul_busy_q && !div_busy_q)
		else $error("unit busy while idle");

	// an accepted transaction closes the input until its result is loaded
	a_accept_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input open right after acceptance");

	// a result is loaded only after the command product completed
	a_load_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> !mul_busy_q && $past(state_q) != ST_CMD)
		else $error("result loaded before product done");

endmodule
`default_nettype wire
